@@ src/dcrm_pkg.sv @@
package dcrm_pkg;

  // default ring depth per channel
  localparam int unsigned DepthDefault = 128;

  // configuration reset values
  localparam logic [15:0] DebounceReset = 16'd50;
  localparam logic [15:0] WindowReset   = 16'd1000;

  // rate saturates here
  localparam logic [7:0] RateMax = 8'd255;

  // register index codes, taken from paddr[2]
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_WINDOW   = 1'b1;

  // command from the top level to one channel
  typedef struct packed {
    logic start;  // item accepted this cycle
    logic rise;   // rising edge of the button level
    logic pop;    // held rate moves to the output register
  } dcrm_ctrl_t;

  // status from one channel to the top level
  typedef struct packed {
    logic ready;  // can take an item
    logic full;   // rate of the last item is held
  } dcrm_stat_t;

endpackage

@@ src/debounced_click_rate_meter_core.sv @@
// Two-channel press-rate meter. Each accepted item records a debounced
// rising edge of the left and right button into that channel's ring of
// HISTORY_DEPTH 64-bit timestamps, then counts the stored stamps younger than
// window_ms. The rate goes to a holding register in the channel once the
// scan ends, and on to the output register when that is free; a further item
// is taken only after the held rate has moved on. The ring of each channel
// sits in one memory with one read port, read one entry per cycle, so the
// scan length sets the rate. After reset a clearing pass empties the rings;
// in_stall stays high until it ends.
// A finished result waits in an output register, so the next item can be
// taken while out_stall holds the previous one.
// Registers: debounce_ms at byte address 0, window_ms at byte address 4.
module debounced_click_rate_meter_core
  import dcrm_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = DepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_now_ms,
  input  logic        in_left_level,
  input  logic        in_right_level,
  input  logic        in_left_prev_level,
  input  logic        in_right_prev_level,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_left_rate,
  output logic [7:0]  out_right_rate,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] debounce_r;
  logic [15:0] window_r;
  logic        out_valid_r;
  logic [7:0]  out_left_r;
  logic [7:0]  out_right_r;

  dcrm_ctrl_t  l_ctrl;
  dcrm_ctrl_t  r_ctrl;
  dcrm_stat_t  l_stat;
  dcrm_stat_t  r_stat;
  logic [7:0]  l_rate;
  logic [7:0]  r_rate;
  logic        take;
  logic        load;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DebounceReset;
      window_r   <= WindowReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_DEBOUNCE: debounce_r <= pwdata[15:0];
        REG_WINDOW:   window_r   <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEBOUNCE: prdata = {16'd0, debounce_r};
      REG_WINDOW:   prdata = {16'd0, window_r};
      default:      prdata = 32'd0;
    endcase
  end

  // item acceptance, both channels run in lockstep
  assign in_stall = !(l_stat.ready && r_stat.ready);
  assign take     = in_valid && !in_stall;

  // move held rates to the output register when it is free
  assign load = l_stat.full && (!out_valid_r || !out_stall);

  assign l_ctrl.start = take;
  assign l_ctrl.rise  = in_left_level && !in_left_prev_level;
  assign l_ctrl.pop   = load;
  assign r_ctrl.start = take;
  assign r_ctrl.rise  = in_right_level && !in_right_prev_level;
  assign r_ctrl.pop   = load;

  dcrm_channel #(
    .DEPTH(HISTORY_DEPTH)
  ) u_left (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (l_ctrl),
    .now         (in_now_ms),
    .debounce_ms (debounce_r),
    .window_ms   (window_r),
    .stat        (l_stat),
    .rate        (l_rate)
  );

  dcrm_channel #(
    .DEPTH(HISTORY_DEPTH)
  ) u_right (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (r_ctrl),
    .now         (in_now_ms),
    .debounce_ms (debounce_r),
    .window_ms   (window_r),
    .stat        (r_stat),
    .rate        (r_rate)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_left_r  <= l_rate;
      out_right_r <= r_rate;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_left_rate  = out_left_r;
  assign out_right_rate = out_right_r;

  // the two channels finish together
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (l_stat.full == r_stat.full) && (l_stat.ready == r_stat.ready))
    else $error("channels out of step");

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !load)
    else $error("held result overwritten");

  // an item is never taken while a rate is still held
  a_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> !l_stat.full)
    else $error("item taken while a rate is held");

endmodule

@@ src/dcrm_channel.sv @@
module dcrm_channel
  import dcrm_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dcrm_ctrl_t  ctrl,
  input  logic [63:0] now,
  input  logic [15:0] debounce_ms,
  input  logic [15:0] window_ms,
  output dcrm_stat_t  stat,
  output logic [7:0]  rate
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0]    state_r;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] slot_r;
  logic [63:0]   last_r;
  logic [63:0]   now_r;
  logic [CW-1:0] count_r;
  logic [63:0]   rdata_r;
  logic          rvld_r;
  logic          rlast_r;
  logic          full_r;
  logic [7:0]    rate_r;

  logic [63:0]   mem [DEPTH];

  logic          press;
  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata;
  logic          hit;
  logic [CW-1:0] sum;
  logic [7:0]    sum_sat;
  logic          idx_end;

  // debounce check on a rising edge
  assign press = ctrl.rise && ((now - last_r) > {48'd0, debounce_ms});

  // stored stamp inside the window
  assign hit = (rdata_r != 64'd0) && ((now_r - rdata_r) < {48'd0, window_ms});

  assign sum     = count_r + CW'(hit);
  assign sum_sat = (32'(sum) > 32'(RateMax)) ? RateMax : 8'(sum);
  assign idx_end = (idx_r == LastIdx);

  // single write port: clearing pass or press record
  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = 64'd0;
    if (state_r == ST_CLEAR) begin
      we = 1'b1;
    end else if (state_r == ST_IDLE && ctrl.start && press) begin
      we    = 1'b1;
      waddr = slot_r;
      wdata = now;
    end
  end

  // stamp ring, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[idx_r];
  end

  // sequencer: clear after reset, then one scan of the ring per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r   <= '0;
      slot_r  <= '0;
      last_r  <= 64'd0;
      count_r <= '0;
      rvld_r  <= 1'b0;
      rlast_r <= 1'b0;
      full_r  <= 1'b0;
    end else begin
      rvld_r  <= (state_r == ST_SCAN);
      rlast_r <= (state_r == ST_SCAN) && idx_end;
      if (rvld_r) begin
        count_r <= sum;
      end
      if (rlast_r) begin
        full_r <= 1'b1;
      end else if (ctrl.pop) begin
        full_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          idx_r <= idx_end ? '0 : idx_r + 1'b1;
          if (idx_end) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (ctrl.start) begin
            count_r <= '0;
            idx_r   <= '0;
            state_r <= ST_SCAN;
            if (press) begin
              slot_r <= (slot_r == LastIdx) ? '0 : slot_r + 1'b1;
              last_r <= now;
            end
          end
        end
        ST_SCAN: begin
          idx_r <= idx_end ? '0 : idx_r + 1'b1;
          if (idx_end) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // item time and final rate
  always_ff @(posedge clk) begin
    if (ctrl.start && state_r == ST_IDLE) begin
      now_r <= now;
    end
    if (rlast_r) begin
      rate_r <= sum_sat;
    end
  end

  assign stat.ready = (state_r == ST_IDLE) && !full_r && !rvld_r;
  assign stat.full  = full_r;
  assign rate       = rate_r;

  // an accepted item always starts a scan
  a_start_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.start && stat.ready) |=> (state_r == ST_SCAN))
    else $error("item start did not enter the scan");

  // the last read belongs to a running scan
  a_last_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rlast_r |-> (rvld_r && $past(state_r) == ST_SCAN))
    else $error("scan end flag outside a scan");

  // a held rate never overlaps a scan
  a_full_idle: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (state_r == ST_IDLE && !rvld_r))
    else $error("rate held while scanning");

  // write slot stays inside the ring
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= LastIdx)
    else $error("write slot beyond ring depth");

endmodule

@@ tb/sv/debounced_click_rate_meter_core_tb.sv @@
module debounced_click_rate_meter_core_tb
  import dcrm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RingDepth = DepthDefault;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned LeftCh = 0;
  localparam int unsigned RightCh = 1;

  // one input item as the block sees it
  typedef struct packed {
    logic [63:0] now_ms;
    logic        left_level;
    logic        right_level;
    logic        left_prev_level;
    logic        right_prev_level;
  } click_item_t;

  // the two rates of one result item
  typedef struct packed {
    logic [7:0] left_rate;
    logic [7:0] right_rate;
  } rate_pair_t;

  // press-rate predictor with its queue of expected rate pairs
  class press_rate_tracker;
    logic [15:0] debounce_ms = DebounceReset;
    logic [15:0] window_ms = WindowReset;
    logic [63:0] stamps[2][RingDepth];
    int unsigned slot[2];
    logic [63:0] last_press[2];
    rate_pair_t  expected_rates[$];
    int unsigned errors = 0;

    function new();
      for (int c = 0; c < 2; c++) begin
        slot[c] = 0;
        last_press[c] = '0;
        for (int i = 0; i < RingDepth; i++) stamps[c][i] = '0;
      end
    endfunction

    function void set_register(logic reg_sel, logic [15:0] value);
      if (reg_sel == REG_DEBOUNCE) debounce_ms = value;
      else window_ms = value;
    endfunction

    // debounce one edge, store it, then count young stamps
    function logic [7:0] count_recent(int unsigned ch, logic [63:0] now, logic level,
                                      logic prev);
      int unsigned n;
      logic [63:0] gap;
      n = 0;
      gap = now - last_press[ch];
      if (level && !prev && gap > {48'b0, debounce_ms}) begin
        stamps[ch][slot[ch]] = now;
        slot[ch] = (slot[ch] + 1) % RingDepth;
        last_press[ch] = now;
      end
      for (int i = 0; i < RingDepth; i++) begin
        if (stamps[ch][i] != 64'd0 && (now - stamps[ch][i]) < {48'b0, window_ms}) n++;
      end
      if (n > RateMax) n = RateMax;
      return n[7:0];
    endfunction

    function void note_item(click_item_t it);
      rate_pair_t r;
      r.left_rate = count_recent(LeftCh, it.now_ms, it.left_level, it.left_prev_level);
      r.right_rate = count_recent(RightCh, it.now_ms, it.right_level, it.right_prev_level);
      expected_rates.push_back(r);
    endfunction

    function void check_result(logic [7:0] left_rate, logic [7:0] right_rate);
      rate_pair_t want;
      if (expected_rates.size() == 0) begin
        $error("result with no item pending: left_rate %0d right_rate %0d",
               left_rate, right_rate);
        errors++;
        return;
      end
      want = expected_rates.pop_front();
      if (left_rate !== want.left_rate) begin
        $error("left_rate: expected %0d, actual %0d", want.left_rate, left_rate);
        errors++;
      end
      if (right_rate !== want.right_rate) begin
        $error("right_rate: expected %0d, actual %0d", want.right_rate, right_rate);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_now_ms = '0;
  logic        in_left_level = 1'b0;
  logic        in_right_level = 1'b0;
  logic        in_left_prev_level = 1'b0;
  logic        in_right_prev_level = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_left_rate;
  logic [7:0]  out_right_rate;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  press_rate_tracker rates = new();

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_run = 0;
  int unsigned cycle_count = 0;
  logic [63:0] sim_now = '0;
  logic        left_held = 1'b0;
  logic        right_held = 1'b0;

  debounced_click_rate_meter_core #(
    .HISTORY_DEPTH(RingDepth)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_now_ms          (in_now_ms),
    .in_left_level      (in_left_level),
    .in_right_level     (in_right_level),
    .in_left_prev_level (in_left_prev_level),
    .in_right_prev_level(in_right_prev_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_left_rate      (out_left_rate),
    .out_right_rate     (out_right_rate),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: short random stalls plus the odd long hold
  always @(negedge clk) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      if ($urandom_range(15) == 0) stall_run <= $urandom_range(300, 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) rates.check_result(out_left_rate, out_right_rate);
  end

  // entered and left at a falling edge
  task automatic send_item(input click_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      repeat ($urandom_range(2 * (RingDepth + 2), 1)) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_now_ms <= it.now_ms;
    in_left_level <= it.left_level;
    in_right_level <= it.right_level;
    in_left_prev_level <= it.left_prev_level;
    in_right_prev_level <= it.right_prev_level;
    do @(posedge clk); while (in_stall);
    rates.note_item(it);
    @(negedge clk);
  endtask

  task automatic press(input logic [63:0] now, input logic ll, input logic lp,
                       input logic rl, input logic rp);
    click_item_t it;
    it.now_ms = now;
    it.left_level = ll;
    it.left_prev_level = lp;
    it.right_level = rl;
    it.right_prev_level = rp;
    send_item(it);
  endtask

  // upper data bits are random and must be dropped by the block
  task automatic write_reg(input logic reg_sel, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    rates.set_register(reg_sel, value);
    @(negedge clk);
  endtask

  task automatic read_back(input logic reg_sel);
    logic [31:0] want;
    want = {16'b0, (reg_sel == REG_DEBOUNCE) ? rates.debounce_ms : rates.window_ms};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {reg_sel, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("prdata of register %0d: expected %0d, actual %0d", reg_sel, want, prdata);
      rates.errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // drop valid and wait until every pending item has come out
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (rates.expected_rates.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // mostly plausible button traffic, some noise and time jumps
  task automatic next_random_item(input int unsigned step_cap, output click_item_t it);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 85) begin
      sim_now = sim_now + 64'($urandom_range(step_cap));
      it.left_prev_level = left_held;
      it.right_prev_level = right_held;
      if ($urandom_range(9) < 6) left_held = ~left_held;
      if ($urandom_range(9) < 6) right_held = ~right_held;
      it.left_level = left_held;
      it.right_level = right_held;
    end else begin
      case (pick % 3)
        0: sim_now = {$urandom, $urandom};
        1: sim_now = sim_now - 64'($urandom_range(70000));
        default: ;
      endcase
      it.left_level = 1'($urandom_range(1));
      it.right_level = 1'($urandom_range(1));
      it.left_prev_level = 1'($urandom_range(1));
      it.right_prev_level = 1'($urandom_range(1));
    end
    it.now_ms = sim_now;
  endtask

  task automatic run_phase(input logic [15:0] debounce, input logic [15:0] window,
                           input int unsigned count, input int unsigned gap_pct,
                           input int unsigned hold_pct);
    click_item_t it;
    int unsigned step_cap;
    settle();
    write_reg(REG_DEBOUNCE, debounce);
    write_reg(REG_WINDOW, window);
    read_back(REG_DEBOUNCE);
    read_back(REG_WINDOW);
    idle_pct = gap_pct;
    stall_pct = hold_pct;
    step_cap = debounce + window / 32 + 8;
    if ($urandom_range(3) == 0) sim_now = {$urandom, $urandom};
    else sim_now = 64'($urandom_range(100000));
    repeat (count) begin
      next_random_item(step_cap, it);
      send_item(it);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    read_back(REG_DEBOUNCE);
    read_back(REG_WINDOW);

    // reset settings: edges, debounce boundary, window boundary
    press(64'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    press(64'd0, 1'b1, 1'b0, 1'b0, 1'b0);
    press(64'd100, 1'b1, 1'b0, 1'b1, 1'b0);
    press(64'd120, 1'b1, 1'b0, 1'b1, 1'b1);
    press(64'd150, 1'b1, 1'b0, 1'b0, 1'b1);
    press(64'd151, 1'b1, 1'b0, 1'b0, 1'b0);
    press(64'd1099, 1'b0, 1'b1, 1'b0, 1'b0);
    press(64'd1100, 1'b1, 1'b1, 1'b1, 1'b1);
    // time going backwards
    press(64'd60, 1'b0, 1'b0, 1'b0, 1'b0);
    // press at time zero lands as an empty slot
    press(64'd0, 1'b1, 1'b0, 1'b0, 1'b0);
    press(64'd10, 1'b1, 1'b0, 1'b0, 1'b0);
    // largest time, then wrap to zero
    press('1, 1'b1, 1'b0, 1'b1, 1'b0);
    press(64'd0, 1'b1, 1'b1, 1'b1, 1'b1);
    press(64'd5, 1'b0, 1'b1, 1'b0, 1'b1);

    // no debounce, window of zero
    settle();
    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_WINDOW, 16'd0);
    read_back(REG_DEBOUNCE);
    read_back(REG_WINDOW);
    press(64'd20, 1'b1, 1'b0, 1'b1, 1'b0);
    press(64'd20, 1'b1, 1'b0, 1'b1, 1'b0);
    press(64'd21, 1'b1, 1'b0, 1'b1, 1'b0);

    // both registers at their maximum
    settle();
    write_reg(REG_DEBOUNCE, 16'hFFFF);
    write_reg(REG_WINDOW, 16'hFFFF);
    read_back(REG_DEBOUNCE);
    read_back(REG_WINDOW);
    press(64'd30000, 1'b1, 1'b0, 1'b1, 1'b0);
    press(64'd70000, 1'b1, 1'b0, 1'b1, 1'b0);
    press(64'd135535, 1'b0, 1'b0, 1'b0, 1'b0);
    press(64'hA5A5_5A5A_F0F0_0F0F, 1'b1, 1'b0, 1'b1, 1'b0);

    // random traffic over several settings and idling patterns
    run_phase(DebounceReset, WindowReset, 110, 0, 0);
    run_phase(16'd0, 16'hFFFF, 140, 67, 0);
    run_phase(16'hFFFF, 16'd1, 90, 0, 67);
    run_phase(16'($urandom), 16'($urandom_range(65535, 1)), 100, 6, 6);
    run_phase(16'($urandom_range(200)), 16'($urandom_range(65535, 1)), 110, 0, 0);
    run_phase(16'd0, 16'hFFFF, 100, 0, 67);

    settle();
    repeat (RingDepth + 8) @(posedge clk);
    if (rates.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
